// File: src/bdfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdfr_pkg
// Shared widths, constants and types for the binaural dual FIR renderer.
// ----------------------------------------------------------------------------
package bdfr_pkg;

  // Default delay line length
  localparam int TAPS_DEF = 64;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int ITD_W    = 9;
  localparam int WIN_W    = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_ITD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_L = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_R = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

  // Window: Q1.15, unity for the leading ear at tap 0
  localparam logic [WIN_W-1:0] WIN_ONE = 16'd32768;

  // Hann table generation (Q30 sine polynomial)
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0] HANN_DIV_0 = 64'd110;
  localparam logic [63:0] HANN_DIV_1 = 64'd72;
  localparam logic [63:0] HANN_DIV_2 = 64'd42;
  localparam logic [63:0] HANN_DIV_3 = 64'd20;
  localparam logic [63:0] HANN_DIV_4 = 64'd6;

  // Product of sample (Q1.15), gain (Q2.14) and window (Q1.15): Q44
  localparam int MUL_A_W     = 32;
  localparam int MUL_B_W     = GAIN_W + 1;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int ROUND_SHIFT = 29;

  // Shared multiplier pass select
  typedef struct packed {
    logic ld_gain;  // prod = sample * gain
    logic ld_win;   // prod = prod * window
  } mac_ctrl_t;

endpackage

// File: src/bdfr_delay_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdfr_delay_mem
// Circular sample store for the shared delay line, registered read.
// ----------------------------------------------------------------------------
module bdfr_delay_mem
  import bdfr_pkg::*;
#(
  parameter int TAPS = TAPS_DEF,
  localparam int AW  = $clog2(TAPS)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic signed [SAMPLE_W-1:0] wr_data,
  input  logic [AW-1:0]              rd_addr,
  output logic signed [SAMPLE_W-1:0] rd_data
);

  logic signed [SAMPLE_W-1:0] mem [TAPS];
  logic signed [SAMPLE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/bdfr_hann_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdfr_hann_rom
// Hann window table, Q1.15, built at elaboration; registered read.
// ----------------------------------------------------------------------------
module bdfr_hann_rom
  import bdfr_pkg::*;
#(
  parameter int TAPS = TAPS_DEF,
  localparam int AW  = $clog2(TAPS)
) (
  input  logic             clk,
  input  logic [AW-1:0]    idx,
  output logic [WIN_W-1:0] win
);

  logic [WIN_W-1:0] rom_w [TAPS];
  logic [WIN_W-1:0] win_r;

  for (genvar gi = 0; gi < TAPS; gi++) begin : g_win
    // fold onto the rising half, then sin(t)^2 via truncating Horner steps
    localparam int KI = (gi <= TAPS - 1 - gi) ? gi : TAPS - 1 - gi;
    localparam logic [63:0] T  = (64'(KI) * PI_Q30) / 64'(TAPS - 1);
    localparam logic [63:0] T2 = (T * T) >> 30;
    localparam logic [63:0] H1 = ONE_Q30 - (((T2 * ONE_Q30) >> 30) / HANN_DIV_0);
    localparam logic [63:0] H2 = ONE_Q30 - (((T2 * H1) >> 30) / HANN_DIV_1);
    localparam logic [63:0] H3 = ONE_Q30 - (((T2 * H2) >> 30) / HANN_DIV_2);
    localparam logic [63:0] H4 = ONE_Q30 - (((T2 * H3) >> 30) / HANN_DIV_3);
    localparam logic [63:0] H5 = ONE_Q30 - (((T2 * H4) >> 30) / HANN_DIV_4);
    localparam logic [63:0] S  = (T * H5) >> 30;
    localparam logic [63:0] W  = (S * S + (64'd1 << 44)) >> 45;
    assign rom_w[gi] = WIN_W'(W);
  end

  always_ff @(posedge clk) begin
    win_r <= rom_w[idx];
  end

  assign win = win_r;

endmodule

// File: src/bdfr_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdfr_mac
// Shared multiplier: sample*gain, then *window; Q44 -> Q15 round and clamp.
// ----------------------------------------------------------------------------
module bdfr_mac
  import bdfr_pkg::*;
(
  input  logic                       clk,
  input  mac_ctrl_t                  ctrl,
  input  logic signed [SAMPLE_W-1:0] x_i,
  input  logic [GAIN_W-1:0]          gain_i,
  input  logic [WIN_W-1:0]           win_i,
  output logic signed [SAMPLE_W-1:0] res_o
);

  localparam logic signed [PROD_W-1:0] HALF    = PROD_W'(1) <<< (ROUND_SHIFT - 1);
  localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] SAT_MIN = -SAT_MAX - PROD_W'(1);

  logic signed [PROD_W-1:0]  prod_r;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [PROD_W-1:0]  rnd_sum;
  logic signed [PROD_W-1:0]  rnd_q;

  // first pass takes the sample, second pass re-uses the held product
  always_comb begin
    if (ctrl.ld_win) begin
      mul_a = prod_r[MUL_A_W-1:0];
      mul_b = signed'({1'b0, win_i});
    end else begin
      mul_a = MUL_A_W'(x_i);
      mul_b = signed'({1'b0, gain_i});
    end
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (ctrl.ld_gain || ctrl.ld_win) begin
      prod_r <= mul_p;
    end
  end

  // floor((p + 2^28) / 2^29), then clamp
  assign rnd_sum = prod_r + HALF;
  assign rnd_q   = rnd_sum >>> ROUND_SHIFT;

  always_comb begin
    if (rnd_q > SAT_MAX) begin
      res_o = SAMPLE_W'(SAT_MAX);
    end else if (rnd_q < SAT_MIN) begin
      res_o = SAMPLE_W'(SAT_MIN);
    end else begin
      res_o = rnd_q[SAMPLE_W-1:0];
    end
  end

endmodule

// File: src/binaural_dual_fir_renderer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binaural_dual_fir_renderer_core
// Mono-in, two-ear FIR renderer with interaural delay and per-ear gain.
// ----------------------------------------------------------------------------
// Each input transaction carries one mono Q1.15 sample, which is pushed into a
// TAPS-deep delay line (a circular RAM, zero after reset) and yields one output
// transaction holding a left and a right Q1.15 sample. With a signed
// interaural delay d, the left ear reads tap max(0,d) and the right ear tap
// max(0,-d), each weighted by its Q2.14 ear gain times a Hann window value;
// the leading ear gets unity window at tap 0. Results are rounded half up and
// saturated to 16 bits. Zero delay gives silence on both ears, and a delay
// that reaches past the line silences the lagging ear. Each item passes
// through acceptance, then four steps per ear (address, sample*gain, *window,
// round) through the single shared multiplier, then the output register load.
// The block accepts nothing while an item is in flight; the output register
// lets the next item start while a result waits.
// Config writes (delay, left gain, right gain) are expected while idle.
// ----------------------------------------------------------------------------
module binaural_dual_fir_renderer_core
  import bdfr_pkg::*;
#(
  parameter int TAPS = TAPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [SAMPLE_W-1:0]  in_sample_in,
  // output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [SAMPLE_W-1:0]  out_left_out,
  output logic signed [SAMPLE_W-1:0]  out_right_out,
  // config write port
  input  logic                        cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data
);

  localparam int AW = $clog2(TAPS);
  localparam int FW = $clog2(TAPS + 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ADDR = 6'b000010,
    ST_MUL1 = 6'b000100,
    ST_MUL2 = 6'b001000,
    ST_RND  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // config registers
  logic signed [ITD_W-1:0] itd_r;
  logic [GAIN_W-1:0]       gain_left_r;
  logic [GAIN_W-1:0]       gain_right_r;

  // delay line bookkeeping
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] wr_ptr_inc;
  logic [FW-1:0] fill_r;

  // per-ear sequencing
  logic ear_sel_r;          // 0: left, 1: right
  logic tap_ok_r;           // tap holds a sample written since reset
  logic full_r;             // leading ear: unity window

  logic signed [SAMPLE_W-1:0] left_res_r;
  logic signed [SAMPLE_W-1:0] right_res_r;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_left_r;
  logic signed [SAMPLE_W-1:0] out_right_r;

  logic in_acc;
  logic out_acc;

  // tap decode
  logic [ITD_W-1:0]   pos;
  logic               full_c;
  logic               tap_ok_c;
  logic [AW-1:0]      tap_idx;
  logic [AW:0]        addr_diff;
  logic [AW-1:0]      rd_addr;

  logic signed [SAMPLE_W-1:0] mem_q;
  logic [WIN_W-1:0]           win_q;
  logic signed [SAMPLE_W-1:0] mac_x;
  logic [GAIN_W-1:0]          mac_gain;
  logic [WIN_W-1:0]           mac_win;
  logic signed [SAMPLE_W-1:0] mac_res;
  mac_ctrl_t                  mac_ctrl;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  assign wr_ptr_inc = (wr_ptr_r == AW'(TAPS - 1)) ? '0 : wr_ptr_r + AW'(1);

  // Left listens at max(0,d), right at max(0,-d); the other ear leads.
  always_comb begin
    if (!ear_sel_r) begin
      full_c = itd_r < 0;
      pos    = full_c ? '0 : itd_r;
    end else begin
      full_c = itd_r > 0;
      pos    = full_c ? '0 : ITD_W'(-itd_r);
    end
  end

  // fill_r never exceeds TAPS, so this also covers the in-range check
  assign tap_ok_c  = 32'(pos) < 32'(fill_r);
  assign tap_idx   = tap_ok_c ? AW'(pos) : '0;
  assign addr_diff = {1'b0, wr_ptr_r} - {1'b0, tap_idx};
  assign rd_addr   = addr_diff[AW] ? AW'(addr_diff + (AW + 1)'(TAPS)) : addr_diff[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_ADDR;
      ST_ADDR: state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_RND;
      ST_RND:  state_nxt = ear_sel_r ? ST_DONE : ST_ADDR;
      ST_DONE: if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // config decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      itd_r        <= '0;
      gain_left_r  <= GAIN_RESET;
      gain_right_r <= GAIN_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ITD:    itd_r        <= signed'(cfg_data[ITD_W-1:0]);
        CFG_GAIN_L: gain_left_r  <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_R: gain_right_r <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // write pointer and fill count (unwritten taps read as zero)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      fill_r   <= '0;
    end else if (in_acc) begin
      wr_ptr_r <= wr_ptr_inc;
      if (fill_r != FW'(TAPS)) begin
        fill_r <= fill_r + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ear_sel_r <= 1'b0;
    end else if (in_acc) begin
      ear_sel_r <= 1'b0;
    end else if (state_r == ST_RND) begin
      ear_sel_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_ADDR) begin
      tap_ok_r <= tap_ok_c;
      full_r   <= full_c;
    end
    if (state_r == ST_RND) begin
      if (ear_sel_r) begin
        right_res_r <= mac_res;
      end else begin
        left_res_r <= mac_res;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
      out_left_r  <= left_res_r;
      out_right_r <= right_res_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;

  // shared multiplier operands
  assign mac_x          = tap_ok_r ? mem_q : '0;
  assign mac_gain       = ear_sel_r ? gain_right_r : gain_left_r;
  assign mac_win        = full_r ? WIN_ONE : win_q;
  assign mac_ctrl.ld_gain = (state_r == ST_MUL1);
  assign mac_ctrl.ld_win  = (state_r == ST_MUL2);

  bdfr_delay_mem #(
    .TAPS (TAPS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (wr_ptr_inc),
    .wr_data (in_sample_in),
    .rd_addr (rd_addr),
    .rd_data (mem_q)
  );

  bdfr_hann_rom #(
    .TAPS (TAPS)
  ) u_rom (
    .clk (clk),
    .idx (tap_idx),
    .win (win_q)
  );

  bdfr_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .x_i    (mac_x),
    .gain_i (mac_gain),
    .win_i  (mac_win),
    .res_o  (mac_res)
  );

endmodule
